### sv/vpa_pkg.sv
// shared types and codes for the variable partition allocator
`default_nettype none
package vpa_pkg;
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NO_OWNER = 2'd3
	} status_t;
	localparam logic [0:0] OP_ALLOC = 1'b0;
	localparam logic [0:0] OP_FREE  = 1'b1;
	localparam int unsigned REG_FIT_MODE = 0;
	localparam int unsigned REG_MEM_SIZE = 1;
	localparam logic [15:0] MEM_SIZE_RESET = 16'd640;
endpackage
`default_nettype wire

### sv/variable_partition_allocator.sv
// top level: partition table with first or best fit allocation and merging free
`default_nettype none
// An allocate or free request is scanned over the table one entry a cycle by
// a single shared compare unit, and then the table is shifted one entry a
// cycle to insert or remove a partition. in_stall is high from acceptance
// until the result is presented. A waiting result also holds in_stall high,
// so the next request is taken at the earliest in the cycle that the result
// is taken.
// Writing memory_size resets the table to one hole.
module variable_partition_allocator
	import vpa_pkg::*;
#(
	parameter int MAX_PARTITIONS = 16,
	parameter int ADDR_BITS      = 16,
	parameter int ID_BITS        = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [ADDR_BITS-1:0]  cfg_index,
	input  wire [ADDR_BITS-1:0]  cfg_data,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire                  opcode,
	input  wire [ID_BITS-1:0]    owner_id,
	input  wire [ADDR_BITS-1:0]  request_size,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [1:0]           status,
	output logic [ADDR_BITS-1:0] block_start,
	output logic [ADDR_BITS-1:0] block_size
);
	localparam int IW = $clog2(MAX_PARTITIONS);
	localparam int CW = $clog2(MAX_PARTITIONS + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_PARTITIONS);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_SHIFT_UP, S_SHIFT_DN, S_MERGE, S_OUT
	} state_t;

	state_t               state_q;
	logic [ADDR_BITS-1:0] start_q [MAX_PARTITIONS];
	logic [ADDR_BITS-1:0] size_q  [MAX_PARTITIONS];
	logic [ID_BITS-1:0]   owner_q [MAX_PARTITIONS];
	logic                 used_q  [MAX_PARTITIONS];
	logic [CW-1:0]        count_q;
	logic                 fit_q;
	logic                 op_q;
	logic [ID_BITS-1:0]   id_q;
	logic [ADDR_BITS-1:0] req_q;
	logic [CW-1:0]        k_q;
	logic [IW-1:0]        pick_q;
	logic                 found_q;
	logic [ADDR_BITS-1:0] best_q;
	logic [CW-1:0]        rm_q;     // entry to remove in shift-down
	logic                 left_q;   // left merge pending after right one

	logic [IW-1:0] ki;
	logic          hit;
	logic [ADDR_BITS-1:0] sz_k;
	logic          in_acc;

	assign ki     = k_q[IW-1:0];
	assign sz_k   = size_q[ki];
	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);

	// shared compare unit for the scan
	always_comb begin
		if (op_q == OP_ALLOC)
			hit = !used_q[ki] && (sz_k >= req_q) && (req_q != '0);
		else
			hit = used_q[ki] && (owner_q[ki] == id_q);
	end

	// sequencer and table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fit_q       <= 1'b0;
			count_q     <= CW'(1);
			out_valid   <= 1'b0;
			op_q        <= 1'b0;
			id_q        <= '0;
			req_q       <= '0;
			k_q         <= '0;
			pick_q      <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			rm_q        <= '0;
			left_q      <= 1'b0;
			status      <= ST_OK;
			block_start <= '0;
			block_size  <= '0;
			for (int i = 0; i < MAX_PARTITIONS; i++) begin
				start_q[i] <= '0;
				size_q[i]  <= (i == 0) ? ADDR_BITS'(MEM_SIZE_RESET) : '0;
				owner_q[i] <= '0;
				used_q[i]  <= 1'b0;
			end
		end else begin
			if (out_valid && !out_stall && state_q != S_OUT)
				out_valid <= 1'b0;
			if (cfg_we && cfg_index == ADDR_BITS'(REG_FIT_MODE))
				fit_q <= cfg_data[0];
			if (cfg_we && cfg_index == ADDR_BITS'(REG_MEM_SIZE)) begin
				count_q <= CW'(1);
				for (int i = 0; i < MAX_PARTITIONS; i++) begin
					start_q[i] <= '0;
					size_q[i]  <= (i == 0) ? cfg_data : '0;
					owner_q[i] <= '0;
					used_q[i]  <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q    <= opcode;
						id_q    <= owner_id;
						req_q   <= request_size;
						k_q     <= '0;
						found_q <= 1'b0;
						left_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (k_q >= count_q) begin
						state_q <= S_DECIDE;
					end else begin
						k_q <= k_q + CW'(1);
						if (hit) begin
							if (op_q == OP_FREE || fit_q == 1'b0) begin
								if (!found_q) begin
									pick_q  <= ki;
									found_q <= 1'b1;
									state_q <= S_DECIDE;
								end
							end else if (!found_q || sz_k <= best_q) begin
								pick_q  <= ki;
								best_q  <= sz_k;
								found_q <= 1'b1;
							end
						end
					end
				end
				S_DECIDE: begin
					block_start <= '0;
					block_size  <= '0;
					state_q     <= S_OUT;
					if (!found_q) begin
						status <= (op_q == OP_ALLOC) ? ST_NO_FIT : ST_NO_OWNER;
					end else if (op_q == OP_ALLOC) begin
						if (size_q[pick_q] == req_q) begin
							used_q[pick_q]  <= 1'b1;
							owner_q[pick_q] <= id_q;
							status      <= ST_OK;
							block_start <= start_q[pick_q];
							block_size  <= req_q;
						end else if (count_q >= CMAX) begin
							status <= ST_FULL;
						end else begin
							status      <= ST_OK;
							block_start <= start_q[pick_q];
							block_size  <= req_q;
							k_q         <= count_q;
							state_q     <= S_SHIFT_UP;
						end
					end else begin
						status      <= ST_OK;
						block_start <= start_q[pick_q];
						block_size  <= size_q[pick_q];
						used_q[pick_q]  <= 1'b0;
						owner_q[pick_q] <= '0;
						state_q     <= S_MERGE;
					end
				end
				S_SHIFT_UP: begin
					// move entries up one place, then split the hole
					if (k_q > CW'(pick_q)) begin
						start_q[ki] <= start_q[ki - IW'(1)];
						size_q[ki]  <= size_q[ki - IW'(1)];
						owner_q[ki] <= owner_q[ki - IW'(1)];
						used_q[ki]  <= used_q[ki - IW'(1)];
						k_q <= k_q - CW'(1);
					end else begin
						count_q <= count_q + CW'(1);
						used_q[pick_q]  <= 1'b1;
						owner_q[pick_q] <= id_q;
						size_q[pick_q]  <= req_q;
						start_q[pick_q + IW'(1)] <= start_q[pick_q] + req_q;
						size_q[pick_q + IW'(1)]  <= size_q[pick_q] - req_q;
						state_q <= S_OUT;
					end
				end
				S_MERGE: begin
					// right neighbour first, then left
					if (!left_q && (CW'(pick_q) + CW'(1) < count_q)
							&& !used_q[pick_q + IW'(1)]) begin
						size_q[pick_q] <= size_q[pick_q] + size_q[pick_q + IW'(1)];
						rm_q    <= CW'(pick_q) + CW'(1);
						k_q     <= CW'(pick_q) + CW'(1);
						left_q  <= 1'b1;
						state_q <= S_SHIFT_DN;
					end else if (pick_q != '0 && !used_q[pick_q - IW'(1)]) begin
						size_q[pick_q - IW'(1)] <=
							size_q[pick_q - IW'(1)] + size_q[pick_q];
						rm_q    <= CW'(pick_q);
						k_q     <= CW'(pick_q);
						pick_q  <= '0;
						left_q  <= 1'b1;
						state_q <= S_SHIFT_DN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SHIFT_DN: begin
					if (k_q + CW'(1) < count_q) begin
						start_q[ki] <= start_q[ki + IW'(1)];
						size_q[ki]  <= size_q[ki + IW'(1)];
						owner_q[ki] <= owner_q[ki + IW'(1)];
						used_q[ki]  <= used_q[ki + IW'(1)];
						k_q <= k_q + CW'(1);
					end else begin
						start_q[ki] <= '0;
						size_q[ki]  <= '0;
						owner_q[ki] <= '0;
						used_q[ki]  <= 1'b0;
						count_q <= count_q - CW'(1);
						// after a right merge, try the left one
						state_q <= (pick_q != '0 && rm_q == CW'(pick_q) + CW'(1))
							? S_MERGE : S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(1) && count_q <= CMAX) else $error("count out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accept while busy");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT) else $error("stray result");
`endif
endmodule
`default_nettype wire
